// File: hdl/sard_pkg.sv
// ----------------------------------------------------------------------------
// sard_pkg
// Shared types and constants for the two-queue ratio dispatcher: field widths,
// operation codes, sequencer states and the controller/datapath structs.
// ----------------------------------------------------------------------------
package sard_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned RATIO_W = 8;

  localparam logic [RATIO_W-1:0] BATCH_RATIO_RST = 8'd4;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_DRAIN    = 2'd2,
    OP_MERGE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REJECT,
    ST_POP,
    ST_EMIT,
    ST_SCAN,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_item;
    logic push;
    logic pop;
    logic load_pop;
    logic load_reject;
    logic scan_start;
    logic scan_rd;
    logic idx_inc;
    logic shift_rd;
    logic shift_wr;
    logic count_dec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic sel_full;
    logic pop_avail;
    logic rd_last;
    logic scan_done;
    logic match;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/sard_req_if.sv
// ----------------------------------------------------------------------------
// sard_req_if
// Request channel: operation, tag and queue select with valid/ready.
// ----------------------------------------------------------------------------
interface sard_req_if import sard_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [TAG_W-1:0] request_tag;
  logic             is_sync;

  modport source (output valid, output operation, output request_tag, output is_sync,
                  input ready);
  modport sink   (input valid, input operation, input request_tag, input is_sync,
                  output ready);

endinterface

// File: hdl/sard_rsp_if.sv
// ----------------------------------------------------------------------------
// sard_rsp_if
// Result channel: dispatched or rejected tag with status and last marker.
// ----------------------------------------------------------------------------
interface sard_rsp_if import sard_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] out_tag;
  logic             from_sync;
  logic             status;
  logic             last;

  modport source (output valid, output out_tag, output from_sync, output status,
                  output last, input ready);
  modport sink   (input valid, input out_tag, input from_sync, input status,
                  input last, output ready);

endinterface

// File: hdl/sard_dp.sv
// ----------------------------------------------------------------------------
// sard_dp
// Datapath: tag memory holding both circular queues, head pointers, counts,
// item registers, scan index, read register and the result register.
// ----------------------------------------------------------------------------
module sard_dp import sard_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [RATIO_W-1:0] cfg_wdata_i,
  input  logic [OP_W-1:0]    in_op_i,
  input  logic [TAG_W-1:0]   in_tag_i,
  input  logic               in_sync_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [TAG_W-1:0]   out_tag_o,
  output logic               out_sync_o,
  output logic               out_status_o,
  output logic               out_last_o
);

  localparam int unsigned IW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW    = IW + 1;
  localparam int unsigned MEM_N = 2 ** AW;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [IW-1:0] HEAD_MAX = IW'(QUEUE_DEPTH - 1);

  // physical slot of logical position off behind head
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IW-1:0];
  endfunction

  logic [TAG_BITS-1:0] mem [MEM_N];

  logic [IW-1:0]        head_q  [2];
  logic [CW-1:0]        count_q [2];
  logic [RATIO_W-1:0]   ratio_q;
  logic [RATIO_W-1:0]   ratio_left_q;
  op_e                  op_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic                 sel_q;
  logic [CW-1:0]        idx_q;
  logic [TAG_BITS-1:0]  rd_data_q;
  logic                 rd_last_q;
  logic                 rd_sync_q;
  logic                 out_valid_q;
  logic [TAG_W-1:0]     out_tag_q;
  logic                 out_sync_q;
  logic                 out_status_q;
  logic                 out_last_q;

  logic [TAG_BITS+TAG_W-1:0] in_ext, rd_ext, rej_ext;
  logic [TAG_BITS-1:0]  tag_in;
  logic [CW-1:0]        cnt_s, cnt_a, cnt_sel, idx_nxt;
  logic [IW-1:0]        head_sel, head_pop, head_inc;
  logic                 is_disp, sync_ok, async_ok, pop_sync, pop_last, sync_last;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [TAG_BITS-1:0]  wr_data;
  logic                 rd_en, wr_en;

  assign in_ext  = {{TAG_BITS{1'b0}}, in_tag_i};
  assign tag_in  = in_ext[TAG_BITS-1:0];
  assign rd_ext  = {{TAG_W{1'b0}}, rd_data_q};
  assign rej_ext = {{TAG_W{1'b0}}, tag_q};

  assign cnt_s    = count_q[1];
  assign cnt_a    = count_q[0];
  assign cnt_sel  = count_q[sel_q];
  assign head_sel = head_q[sel_q];
  assign idx_nxt  = idx_q + CW'(1);

  // pop selection for dispatch and drain runs
  assign is_disp   = (op_q == OP_DISPATCH);
  assign sync_ok   = (cnt_s != '0) && (!is_disp || ratio_left_q != '0);
  assign async_ok  = (cnt_a != '0);
  assign pop_sync  = sync_ok;
  assign sync_last = ((cnt_s == CW'(1)) || (is_disp && ratio_left_q == RATIO_W'(1)))
                     && (cnt_a == '0);
  assign pop_last  = pop_sync ? sync_last : (is_disp || cnt_a == CW'(1));
  assign head_pop  = head_q[pop_sync];
  assign head_inc  = (head_pop == HEAD_MAX) ? '0 : head_pop + IW'(1);

  always_comb begin
    if (cmd_i.pop) begin
      rd_addr = {pop_sync, head_pop};
    end else if (cmd_i.shift_rd) begin
      rd_addr = {sel_q, wrap_add(head_sel, idx_nxt)};
    end else begin
      rd_addr = {sel_q, wrap_add(head_sel, idx_q)};
    end
    if (cmd_i.push) begin
      wr_addr = {sel_q, wrap_add(head_sel, cnt_sel)};
      wr_data = tag_q;
    end else begin
      wr_addr = {sel_q, wrap_add(head_sel, idx_q)};
      wr_data = rd_data_q;
    end
  end

  assign rd_en = cmd_i.pop || cmd_i.scan_rd || cmd_i.shift_rd;
  assign wr_en = cmd_i.push || cmd_i.shift_wr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q[0]   <= '0;
      head_q[1]   <= '0;
      count_q[0]  <= '0;
      count_q[1]  <= '0;
      ratio_q     <= BATCH_RATIO_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
      if (cmd_i.push) begin
        count_q[sel_q] <= cnt_sel + CW'(1);
      end
      if (cmd_i.count_dec) begin
        count_q[sel_q] <= cnt_sel - CW'(1);
      end
      if (cmd_i.pop) begin
        head_q[pop_sync]  <= head_inc;
        count_q[pop_sync] <= count_q[pop_sync] - CW'(1);
      end
      if (cmd_i.load_pop || cmd_i.load_reject) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q         <= op_e'(in_op_i);
      tag_q        <= tag_in;
      sel_q        <= in_sync_i;
      ratio_left_q <= ratio_q;
    end
    if (cmd_i.pop) begin
      rd_last_q <= pop_last;
      rd_sync_q <= pop_sync;
      if (pop_sync && is_disp) begin
        ratio_left_q <= ratio_left_q - RATIO_W'(1);
      end
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc || cmd_i.shift_wr) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.load_pop) begin
      out_tag_q    <= rd_ext[TAG_W-1:0];
      out_sync_q   <= rd_sync_q;
      out_status_q <= 1'b0;
      out_last_q   <= rd_last_q;
    end else if (cmd_i.load_reject) begin
      out_tag_q    <= rej_ext[TAG_W-1:0];
      out_sync_q   <= sel_q;
      out_status_q <= 1'b1;
      out_last_q   <= 1'b1;
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.sel_full   = (cnt_sel == DEPTH_C);
  assign stat_o.pop_avail  = sync_ok || async_ok;
  assign stat_o.rd_last    = rd_last_q;
  assign stat_o.scan_done  = (idx_q >= cnt_sel);
  assign stat_o.match      = (rd_data_q == tag_q);
  assign stat_o.shift_done = (idx_nxt >= cnt_sel);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_tag_o    = out_tag_q;
  assign out_sync_o   = out_sync_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// File: hdl/sard_ctrl.sv
// ----------------------------------------------------------------------------
// sard_ctrl
// Sequencer: decodes the latched item and steps the datapath through adds,
// pop runs, merge scans and the shift that closes the gap after a removal.
// ----------------------------------------------------------------------------
module sard_ctrl import sard_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.op)
          OP_ADD: begin
            if (stat_i.sel_full) begin
              state_d = ST_REJECT;
            end else begin
              cmd_o.push = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          OP_DISPATCH, OP_DRAIN: state_d = ST_POP;
          OP_MERGE: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_REJECT: begin
        if (stat_i.out_free) begin
          cmd_o.load_reject = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!stat_i.pop_avail) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // result register is empty here: it was free when the pop was issued
        cmd_o.load_pop = 1'b1;
        state_d        = stat_i.rd_last ? ST_IDLE : ST_POP;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.match) begin
          state_d = ST_SHIFT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SHIFT_RD: begin
        if (stat_i.shift_done) begin
          cmd_o.count_dec = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = ST_SHIFT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/sync_async_ratio_dispatcher.sv
// ----------------------------------------------------------------------------
// sync_async_ratio_dispatcher
// Two tag queues (sync, async) with weighted round-robin dispatch, drain,
// add with full rejection and remove-by-tag.
//
//   channel   dir   handshake        payload
//   req       in    valid/ready      operation, request_tag, is_sync
//   rsp       out   valid/ready      out_tag, from_sync, status, last
//   cfg       in    cfg_we_i         cfg_wdata_i -> batch ratio register
//
// One item at a time. Add: the item is pushed, or rejected once the result register is free.
// Dispatch/drain: each result comes from the registered read of the tag memory
// feeding the one result register; a run with nothing queued gives no result.
// Merge: entries are scanned for the tag, then those after the match are shifted down.
// Reset clears counts and pointers at once; there is no clearing pass.
// A stalled rsp holds the sequencer; req is taken again once a run finishes.
// ----------------------------------------------------------------------------
module sync_async_ratio_dispatcher import sard_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RATIO_W-1:0] cfg_wdata_i,
  sard_req_if.sink           req,
  sard_rsp_if.source         rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign req.ready = in_ready;

  sard_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sard_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_op_i      (req.operation),
    .in_tag_i     (req.request_tag),
    .in_sync_i    (req.is_sync),
    .out_ready_i  (rsp.ready),
    .out_valid_o  (rsp.valid),
    .out_tag_o    (rsp.out_tag),
    .out_sync_o   (rsp.from_sync),
    .out_status_o (rsp.status),
    .out_last_o   (rsp.last)
  );

  // a transfer on req is always followed by a busy cycle
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("req taken twice in a row");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_pop || cmd.load_reject) |-> stat.out_free)
    else $error("result register overwritten while pending");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !stat.sel_full)
    else $error("push into full queue");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_pop && stat.rd_last) |=> req.ready)
    else $error("sequencer not idle after last result");

endmodule
